/* rtl/fcskm_pkg.sv */
package fcskm_pkg;

    // default sizes and reset values
    localparam int unsigned ENTRIES_DEF   = 16;
    localparam int unsigned KEY_BYTES_DEF = 8;
    localparam int unsigned CNT_W         = 5;
    localparam int unsigned OP_W          = 2;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_BAD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_FETCH
    } t_state;

    typedef enum logic {
        STS_OK  = 1'b0,
        STS_ERR = 1'b1
    } t_status;

    // bytes up to the first zero byte, zero beyond it; top bit flags the terminator
    function automatic logic [64:0] fcskm_canon(input logic [63:0] raw,
                                                input int unsigned nbytes);
        logic [63:0] key_out;
        logic        done;
        key_out = '0;
        done    = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes && !done) begin
                if (raw[8*i +: 8] == 8'h00) begin
                    done = 1'b1;
                end else begin
                    key_out[8*i +: 8] = raw[8*i +: 8];
                end
            end
        end
        return {done, key_out};
    endfunction

endpackage

/* rtl/fixed_capacity_string_key_map.sv */
// channel     | dir | handshake                       | payload
// ------------+-----+---------------------------------+-----------------------------------
// s_axis      | in  | s_axis_tvalid / s_axis_tready   | tuser: operation; tdata: key, value
// m_axis      | out | m_axis_tvalid / m_axis_tready   | tuser: status; tdata: value, occupancy
// cfg         | in  | i_cfg_valid / o_cfg_ready       | slots_in_use_limit
//
// from acceptance to a loaded result one word passes through a key ram read per slot up to
// the limit (16 by default), a drain of the compare, the execute state and the value ram
// fetch; the key ram read port sets the pace, and a new word is taken only back in idle,
// after the fetch has loaded the result of the last, which it holds back under back-pressure
// reset is synchronous, active low; it frees every slot and zeroes the occupancy, with no
// clearing pass since the slot valid bits are flip-flops; a limit write waits for idle
module fixed_capacity_string_key_map #(
    parameter int unsigned ENTRIES   = fcskm_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BYTES = fcskm_pkg::KEY_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,  // key [63:0], write_value [127:64]
    input  logic [fcskm_pkg::OP_W-1:0]    s_axis_tuser,  // operation [1:0]
    // result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [71:0]                   m_axis_tdata,  // read_value [63:0], occupancy [68:64]
    output logic                          m_axis_tuser,  // status [0]
    // limit register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fcskm_pkg::CNT_W-1:0]   i_cfg_data
);

    import fcskm_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    // control
    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [AW-1:0]     r_cmp_idx;
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic              r_free;
    logic [AW-1:0]     r_free_idx;
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_limit;

    // captured word
    t_op               r_op;
    logic [63:0]       r_key;
    logic              r_term;
    logic [63:0]       r_wval;
    logic              r_status;
    logic              r_get_ok;

    // output register
    logic              r_m_valid;
    logic              r_m_status;
    logic [63:0]       r_m_rdval;
    logic [CNT_W-1:0]  r_m_occ;

    // strobes
    logic              in_fire;
    logic              cfg_fire;
    logic              out_load;
    logic              scan_issue;
    logic              cmp_match;
    logic [CW-1:0]     w_lim;
    logic [64:0]       w_canon;

    // ram ports
    logic              key_we;
    logic [AW-1:0]     key_waddr;
    logic [63:0]       key_rdata;
    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [63:0]       val_wdata;
    logic              val_re;
    logic [AW-1:0]     val_raddr;
    logic [63:0]       val_rdata;

    // execute decisions
    logic              ex_set_upd;
    logic              ex_set_new;
    logic              ex_get;
    logic              ex_del;

    // limit saturates to the table size
    assign w_lim = (int'(r_limit) > int'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_limit);

    assign w_canon    = fcskm_canon(s_axis_tdata[63:0], KEY_BYTES);
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign cfg_fire   = i_cfg_valid && o_cfg_ready;
    // limit writes only between words, never while a search is running
    assign o_cfg_ready = i_rst_n && (r_state == ST_IDLE);

    // compare stage works on the key ram address issued in the previous cycle
    assign cmp_match = r_cmp_vld && r_valid[r_cmp_idx] && (key_rdata == r_key) && !r_hit;

    // decisions taken in the execute cycle
    always_comb begin
        ex_set_upd = 1'b0;
        ex_set_new = 1'b0;
        ex_get     = 1'b0;
        ex_del     = 1'b0;
        case (r_op)
            OP_SET: begin
                if (r_term && r_hit) begin
                    ex_set_upd = 1'b1;
                end else if (r_term && r_free && (int'(r_count) < int'(w_lim))) begin
                    ex_set_new = 1'b1;
                end
            end
            OP_GET: ex_get = r_hit;
            OP_DEL: ex_del = r_hit;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx >= w_lim) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_FETCH;
            ST_FETCH: if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        scan_issue    = 1'b0;
        key_we        = 1'b0;
        key_waddr     = r_free_idx;
        val_we        = 1'b0;
        val_waddr     = r_hit_idx;
        val_wdata     = r_wval;
        val_re        = 1'b0;
        val_raddr     = r_hit_idx;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = i_rst_n;
            end
            ST_SCAN: begin
                scan_issue = (r_idx < w_lim);
            end
            ST_EXEC: begin
                key_we = ex_set_new;
                val_we = ex_set_upd || ex_set_new || ex_del;
                if (ex_set_new) begin
                    val_waddr = r_free_idx;
                end
                if (ex_del) begin
                    val_wdata = '0;
                end
                val_re = ex_get;
            end
            ST_FETCH: begin
                out_load = !r_m_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_limit   <= LIMIT_RESET;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= scan_issue;

            if (in_fire) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end
            if (scan_issue) begin
                r_idx <= CW'(r_idx + 1'b1);
                // lowest free slot, found from the valid bits as the scan goes
                if (!r_valid[r_idx[AW-1:0]] && !r_free) begin
                    r_free <= 1'b1;
                end
            end
            if (cmp_match) begin
                r_hit <= 1'b1;
            end

            if (r_state == ST_EXEC) begin
                if (ex_set_new) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_count <= CNT_W'(r_count + 1'b1);
                end
                if (ex_del) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    if (r_count != '0) begin
                        r_count <= CNT_W'(r_count - 1'b1);
                    end
                end
            end

            // a limit write starts the map afresh
            if (cfg_fire) begin
                r_limit <= i_cfg_data;
                r_valid <= '0;
                r_count <= '0;
            end

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= t_op'(s_axis_tuser);
            r_key  <= w_canon[63:0];
            r_term <= w_canon[64];
            r_wval <= s_axis_tdata[127:64];
        end
        r_cmp_idx <= r_idx[AW-1:0];
        if (scan_issue && !r_valid[r_idx[AW-1:0]] && !r_free) begin
            r_free_idx <= r_idx[AW-1:0];
        end
        if (cmp_match) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_state == ST_EXEC) begin
            r_status <= (ex_set_upd || ex_set_new || ex_get || ex_del) ? STS_OK : STS_ERR;
            r_get_ok <= ex_get;
        end
        if (out_load) begin
            r_m_status <= r_status;
            r_m_rdval  <= r_get_ok ? val_rdata : 64'd0;
            r_m_occ    <= r_count;
        end
    end

    fcskm_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_re    (scan_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (key_rdata)
    );

    fcskm_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {3'b000, r_m_occ, r_m_rdval};

    // occupancy never runs past the usable slots
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= int'(w_lim))
        else $error("occupancy above slot limit");

    // occupancy moves only in the execute cycle or on a limit write
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC && !cfg_fire) |=> $stable(r_count))
        else $error("occupancy changed outside execute");

    // a matched slot always lies inside the searched range
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_hit) |-> (int'(r_hit_idx) < int'(w_lim)))
        else $error("match beyond slot limit");

    // a result appears only after the fetch cycle
    a_result_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_FETCH))
        else $error("result raised outside fetch");

endmodule

/* rtl/fcskm_ram.sv */
module fcskm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
